// ----- rtl/centroid_branch_tracker_macros.svh -----
// Assertion shorthands shared by the tracker RTL.
`ifndef CENTROID_BRANCH_TRACKER_MACROS_SVH
`define CENTROID_BRANCH_TRACKER_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define CTB_ASSERT_NOW(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define CTB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ctb_pkg.sv -----
package ctb_pkg;

   localparam int COORD_W  = 32;
   localparam int BRANCH_W = 16;
   localparam int CNT16_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic [15:0]        layer_index;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic [31:0]        thickness;
      logic               point_present;
      logic               last_point;
      logic               last_layer;
   } req_type;

   typedef struct packed {
      logic [15:0] layer_branch;
      logic [1:0]  event_res;
      logic [15:0] births;
      logic [15:0] deaths;
      logic [15:0] splits;
      logic [31:0] components;
      logic [15:0] branches;
      logic        done_res;
      logic        overflow;
   } rsp_type;

   // one centroid table entry
   typedef struct packed {
      logic [BRANCH_W-1:0]       branch;
      logic signed [COORD_W-1:0] cz;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cx;
   } ent_type;

   localparam logic [1:0] EV_PLANAR  = 2'd0;
   localparam logic [1:0] EV_INHERIT = 2'd1;
   localparam logic [1:0] EV_BIRTH   = 2'd2;
   localparam logic [1:0] EV_SPLIT   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ISO    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DRIFT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIFT_FACTOR = 2'd2;

   localparam logic [31:0] MIN_DRIFT_RST    = 32'h0001_0000;
   localparam logic [15:0] DRIFT_FACTOR_RST = 16'd512;
   localparam logic [15:0] ID_FIRST         = 16'd1;
   localparam logic [15:0] CNT16_MAX        = 16'hFFFF;

   localparam logic [1:0] COORD_X = 2'd0;
   localparam logic [1:0] COORD_Z = 2'd2;

   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_DIV_GO    = 16'h0002,
      S_DIV_WAIT  = 16'h0004,
      S_CLOSE     = 16'h0008,
      S_THR_MUL   = 16'h0010,
      S_THR_SEL   = 16'h0020,
      S_THR_SQ    = 16'h0040,
      S_THR_LD    = 16'h0080,
      S_SCAN_INIT = 16'h0100,
      S_RD        = 16'h0200,
      S_DX        = 16'h0400,
      S_DY        = 16'h0800,
      S_DZ        = 16'h1000,
      S_CMP       = 16'h2000,
      S_CLASS     = 16'h4000,
      S_FIN       = 16'h8000
   } state_type;

   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? CNT16_MAX : s[15:0];
   endfunction

   function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? {64{1'b1}} : s[63:0];
   endfunction

endpackage

// ----- rtl/ctb_ram.sv -----
module ctb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- rtl/ctb_div.sv -----
module ctb_div import ctb_pkg::*; #(
   parameter int SUMW = 49,
   parameter int CNTW = 17
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [SUMW-1:0]    dividend,
   input  logic [CNTW-1:0]           divisor,
   output logic                      done,
   output logic signed [COORD_W-1:0] quotient
);

   localparam int STW = $clog2(SUMW + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [STW-1:0]  step_ff, step_in;
   logic [SUMW-1:0] dvd_ff, dvd_in;
   logic [CNTW-1:0] rem_ff, rem_in;
   logic [CNTW-1:0] dsr_ff, dsr_in;
   logic            neg_ff, neg_in;
   logic            zero_ff, zero_in;
   logic [CNTW:0]   trial;
   logic            ge;
   logic [CNTW:0]   diff;
   logic [COORD_W-1:0] qmag;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      trial   = {rem_ff, dvd_ff[SUMW-1]};
      ge      = trial >= {1'b0, dsr_ff};
      diff    = trial - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = STW'(SUMW);
         dvd_in  = dividend[SUMW-1] ? SUMW'(-dividend) : SUMW'(dividend);
         rem_in  = '0;
         dsr_in  = divisor;
         neg_in  = dividend[SUMW-1];
         zero_in = (divisor == '0);
      end else if (busy_ff) begin
         // shift one quotient bit in per cycle
         rem_in  = ge ? diff[CNTW-1:0] : trial[CNTW-1:0];
         dvd_in  = {dvd_ff[SUMW-2:0], ge};
         step_in = step_ff - 1'b1;
         if (step_ff == STW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   assign qmag     = dvd_ff[COORD_W-1:0];
   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : (neg_ff ? -$signed(qmag) : $signed(qmag));

endmodule

// ----- rtl/centroid_branch_tracker.sv -----
// Centroid branch tracker.
// req_*: contour points, valid/ready. Points of one layer arrive in a row; the
//   point with last_point closes the layer. Non-final points are taken one per
//   cycle. last_layer on the closing point ends the whole sequence.
// rsp_*: one result per closed layer (branch id, event, running counts),
//   valid/ready through an output register.
// csr_*: write-only registers (first iso index, min drift, drift factor); the user
//   must write them only while the block is idle, which the block does not enforce.
// A closing iso point is resolved by three signed divisions by the point count
//   on one radix-2 divider (SUMW = 33 + log2(MAX_POINTS)), then S_CLOSE, the
//   threshold states on the first iso layer (S_THR_MUL, S_THR_SEL, and S_THR_SQ
//   and S_THR_LD unless it saturates), S_SCAN_INIT, per ancestor S_RD, S_DX,
//   S_DY, S_DZ and S_CMP on the shared 32x32 multiplier, S_CLASS and S_FIN.
// req_ready stays low while a layer is being resolved.
// Reset (synchronous) clears all tracking state and loads register defaults.
// A final layer returns the tracking state to its reset values after its result.
// If rsp_ready is low the finished result holds; the next one waits in the
//   final step until the output register frees.
`include "centroid_branch_tracker_macros.svh"

module centroid_branch_tracker import ctb_pkg::*; #(
   parameter int MAX_COMPONENTS = 16,
   parameter int MAX_POINTS     = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
   localparam int SW    = $clog2(MAX_COMPONENTS + 1);
   localparam int CNTW  = $clog2(MAX_POINTS + 1);
   localparam int SUMW  = 33 + $clog2(MAX_POINTS);
   localparam int RAM_DEPTH = 2 * (1 << IW);
   localparam int ENTW  = $bits(ent_type);

   state_type state_ff, state_in;

   logic [15:0] first_iso_ff, first_iso_in;
   logic [31:0] min_drift_ff, min_drift_in;
   logic [15:0] drift_factor_ff, drift_factor_in;

   logic signed [SUMW-1:0] sum_ff [3];
   logic signed [SUMW-1:0] sum_in [3];
   logic [CNTW-1:0] pcnt_ff, pcnt_in;

   logic [15:0] layer_ff, layer_in;
   logic [31:0] thick_ff, thick_in;
   logic        done_ff, done_in;
   logic [1:0]  coord_ff, coord_in;
   logic signed [COORD_W-1:0] cent_ff [3];
   logic signed [COORD_W-1:0] cent_in [3];

   logic                      bank_ff, bank_in;
   logic [SW-1:0]             prev_size_ff, prev_size_in;
   logic [SW-1:0]             cur_size_ff, cur_size_in;
   logic [MAX_COMPONENTS-1:0] claimed_ff, claimed_in;
   logic [SW-1:0]             claim_cnt_ff, claim_cnt_in;
   logic [15:0]               group_index_ff, group_index_in;
   logic                      group_open_ff, group_open_in;

   logic [31:0] thr_ff, thr_in;
   logic [63:0] threshold_sq_ff, threshold_sq_in;
   logic        threshold_set_ff, threshold_set_in;

   logic [63:0] prod_ff, prod_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] best_ff, best_in;
   logic [SW-1:0] scan_cnt_ff, scan_cnt_in;
   logic [IW-1:0] found_idx_ff, found_idx_in;
   logic          found_valid_ff, found_valid_in;
   logic [15:0]   found_branch_ff, found_branch_in;

   logic [15:0] next_id_ff, next_id_in;
   logic [15:0] birth_ff, birth_in;
   logic [15:0] death_ff, death_in;
   logic [15:0] split_ff, split_in;
   logic [31:0] comp_ff, comp_in;
   logic        ovf_ff, ovf_in;

   logic [15:0] branch_ff, branch_in;
   logic [1:0]  event_ff, event_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [31:0] mul_a, mul_b;
   logic        req_fire;
   logic        div_start, div_done;
   logic signed [COORD_W-1:0] div_quot;
   logic        ram_we;
   logic [ENTW-1:0] ram_wdata, ram_rdata;
   ent_type     ent_rd, ent_wr;
   logic [SW-1:0] unclaimed;
   logic [63:0] dist_sum;
   logic [15:0] fresh_branch;
   logic [15:0] cls_branch;
   logic        fin_go;
   logic        cleared_ok;

   function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
      logic signed [32:0] d;
      d = {a[31], a} - {b[31], b};
      return d[32] ? 32'(-d) : d[31:0];
   endfunction

   ctb_div #(
      .SUMW (SUMW),
      .CNTW (CNTW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[coord_ff]),
      .divisor  (pcnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   ctb_ram #(
      .WIDTH (ENTW),
      .DEPTH (RAM_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr ({~bank_ff, cur_size_ff[IW-1:0]}),
      .wr_data (ram_wdata),
      .rd_addr ({bank_ff, scan_cnt_ff[IW-1:0]}),
      .rd_data (ram_rdata)
   );

   assign ent_rd    = ent_type'(ram_rdata);
   assign ram_wdata = ENTW'(ent_wr);
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign unclaimed = prev_size_ff - claim_cnt_ff;
   assign dist_sum  = sat_add64(acc_ff, prod_ff);
   assign fresh_branch = (next_id_ff == '0) ? '0 : next_id_ff;
   assign fin_go    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   assign cleared_ok = (next_id_ff == ID_FIRST) && (prev_size_ff == '0) && (claimed_ff == '0);

   // shared multiplier, registered
   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      state_in        = state_ff;
      first_iso_in    = first_iso_ff;
      min_drift_in    = min_drift_ff;
      drift_factor_in = drift_factor_ff;
      sum_in          = sum_ff;
      pcnt_in         = pcnt_ff;
      layer_in        = layer_ff;
      thick_in        = thick_ff;
      done_in         = done_ff;
      coord_in        = coord_ff;
      cent_in         = cent_ff;
      bank_in         = bank_ff;
      prev_size_in    = prev_size_ff;
      cur_size_in     = cur_size_ff;
      claimed_in      = claimed_ff;
      claim_cnt_in    = claim_cnt_ff;
      group_index_in  = group_index_ff;
      group_open_in   = group_open_ff;
      thr_in          = thr_ff;
      threshold_sq_in = threshold_sq_ff;
      threshold_set_in = threshold_set_ff;
      acc_in          = acc_ff;
      best_in         = best_ff;
      scan_cnt_in     = scan_cnt_ff;
      found_idx_in    = found_idx_ff;
      found_valid_in  = found_valid_ff;
      found_branch_in = found_branch_ff;
      next_id_in      = next_id_ff;
      birth_in        = birth_ff;
      death_in        = death_ff;
      split_in        = split_ff;
      comp_in         = comp_ff;
      ovf_in          = ovf_ff;
      branch_in       = branch_ff;
      event_in        = event_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;
      mul_a           = thr_ff;
      mul_b           = thr_ff;
      div_start       = 1'b0;
      ram_we          = 1'b0;
      cls_branch      = found_branch_ff;
      ent_wr.branch   = cls_branch;
      ent_wr.cx       = cent_ff[0];
      ent_wr.cy       = cent_ff[1];
      ent_wr.cz       = cent_ff[2];

      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_ISO:    first_iso_in    = csr_wdata[15:0];
            CSR_MIN_DRIFT:    min_drift_in    = csr_wdata;
            CSR_DRIFT_FACTOR: drift_factor_in = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_payload.point_present && (pcnt_ff < CNTW'(MAX_POINTS))) begin
                  sum_in[0] = sum_ff[0] + SUMW'(req_payload.point_x);
                  sum_in[1] = sum_ff[1] + SUMW'(req_payload.point_y);
                  sum_in[2] = sum_ff[2] + SUMW'(req_payload.point_z);
                  pcnt_in   = pcnt_ff + 1'b1;
               end
               if (req_payload.last_point) begin
                  layer_in = req_payload.layer_index;
                  thick_in = req_payload.thickness;
                  done_in  = req_payload.last_layer;
                  if (req_payload.layer_index >= first_iso_ff) begin
                     coord_in = COORD_X;
                     state_in = S_DIV_GO;
                  end else begin
                     branch_in = '0;
                     event_in  = EV_PLANAR;
                     state_in  = S_FIN;
                  end
               end
            end
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               cent_in[coord_ff] = div_quot;
               if (coord_ff == COORD_Z) begin
                  state_in = S_CLOSE;
               end else begin
                  coord_in = coord_ff + 1'b1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_CLOSE: begin
            // new layer index: current group becomes the ancestor table
            if (group_open_ff && (layer_ff != group_index_ff)) begin
               death_in     = sat_add16(death_ff, 16'(unclaimed));
               bank_in      = ~bank_ff;
               prev_size_in = cur_size_ff;
               cur_size_in  = '0;
               claimed_in   = '0;
               claim_cnt_in = '0;
            end
            group_open_in  = 1'b1;
            group_index_in = layer_ff;
            state_in = threshold_set_ff ? S_SCAN_INIT : S_THR_MUL;
         end
         S_THR_MUL: begin
            mul_a    = {16'b0, drift_factor_ff};
            mul_b    = thick_ff;
            state_in = S_THR_SEL;
         end
         S_THR_SEL: begin
            if (prod_ff[63:40] != '0) begin
               threshold_sq_in  = '1;
               threshold_set_in = 1'b1;
               state_in         = S_SCAN_INIT;
            end else begin
               thr_in   = (prod_ff[39:8] < min_drift_ff) ? min_drift_ff : prod_ff[39:8];
               state_in = S_THR_SQ;
            end
         end
         S_THR_SQ: begin
            state_in = S_THR_LD;
         end
         S_THR_LD: begin
            threshold_sq_in  = prod_ff;
            threshold_set_in = 1'b1;
            state_in         = S_SCAN_INIT;
         end
         S_SCAN_INIT: begin
            scan_cnt_in    = '0;
            best_in        = threshold_sq_ff;
            found_valid_in = 1'b0;
            state_in       = (prev_size_ff == '0) ? S_CLASS : S_RD;
         end
         S_RD: begin
            state_in = S_DX;
         end
         S_DX: begin
            mul_a    = abs_diff(cent_ff[0], ent_rd.cx);
            mul_b    = mul_a;
            state_in = S_DY;
         end
         S_DY: begin
            acc_in   = prod_ff;
            mul_a    = abs_diff(cent_ff[1], ent_rd.cy);
            mul_b    = mul_a;
            state_in = S_DZ;
         end
         S_DZ: begin
            acc_in   = dist_sum;
            mul_a    = abs_diff(cent_ff[2], ent_rd.cz);
            mul_b    = mul_a;
            state_in = S_CMP;
         end
         S_CMP: begin
            // strict compare keeps the first of equal distances
            if (dist_sum < best_ff) begin
               best_in         = dist_sum;
               found_idx_in    = scan_cnt_ff[IW-1:0];
               found_valid_in  = 1'b1;
               found_branch_in = ent_rd.branch;
            end
            scan_cnt_in = scan_cnt_ff + 1'b1;
            state_in = (SW'(scan_cnt_ff + 1'b1) == prev_size_ff) ? S_CLASS : S_RD;
         end
         S_CLASS: begin
            if (found_valid_ff && !claimed_ff[found_idx_ff]) begin
               cls_branch               = found_branch_ff;
               event_in                 = EV_INHERIT;
               claimed_in[found_idx_ff] = 1'b1;
               claim_cnt_in             = claim_cnt_ff + 1'b1;
            end else begin
               cls_branch = fresh_branch;
               if (next_id_ff == '0) begin
                  ovf_in = 1'b1;
               end else begin
                  next_id_in = next_id_ff + 1'b1;
               end
               if (found_valid_ff) begin
                  event_in = EV_SPLIT;
                  split_in = sat_add16(split_ff, ID_FIRST);
               end else begin
                  event_in = EV_BIRTH;
                  birth_in = sat_add16(birth_ff, ID_FIRST);
               end
            end
            ent_wr.branch = cls_branch;
            branch_in     = cls_branch;
            if (cur_size_ff < SW'(MAX_COMPONENTS)) begin
               ram_we      = 1'b1;
               cur_size_in = cur_size_ff + 1'b1;
            end else begin
               ovf_in = 1'b1;
            end
            comp_in  = comp_ff + 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (fin_go) begin
               rsp_valid_in        = 1'b1;
               rsp_in.layer_branch = branch_ff;
               rsp_in.event_res    = event_ff;
               rsp_in.births       = birth_ff;
               rsp_in.deaths       = done_ff ? sat_add16(death_ff, 16'(unclaimed)) : death_ff;
               rsp_in.splits       = split_ff;
               rsp_in.components   = comp_ff;
               rsp_in.branches     = next_id_ff - ID_FIRST;
               rsp_in.done_res     = done_ff;
               rsp_in.overflow     = ovf_ff;
               sum_in[0] = '0;
               sum_in[1] = '0;
               sum_in[2] = '0;
               pcnt_in   = '0;
               if (done_ff) begin
                  prev_size_in     = '0;
                  cur_size_in      = '0;
                  claimed_in       = '0;
                  claim_cnt_in     = '0;
                  group_index_in   = '0;
                  group_open_in    = 1'b0;
                  threshold_sq_in  = '0;
                  threshold_set_in = 1'b0;
                  next_id_in       = ID_FIRST;
                  birth_in         = '0;
                  death_in         = '0;
                  split_in         = '0;
                  comp_in          = '0;
                  ovf_in           = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         first_iso_ff     <= '0;
         min_drift_ff     <= MIN_DRIFT_RST;
         drift_factor_ff  <= DRIFT_FACTOR_RST;
         sum_ff[0]        <= '0;
         sum_ff[1]        <= '0;
         sum_ff[2]        <= '0;
         pcnt_ff          <= '0;
         coord_ff         <= COORD_X;
         bank_ff          <= 1'b0;
         prev_size_ff     <= '0;
         cur_size_ff      <= '0;
         claimed_ff       <= '0;
         claim_cnt_ff     <= '0;
         group_index_ff   <= '0;
         group_open_ff    <= 1'b0;
         threshold_sq_ff  <= '0;
         threshold_set_ff <= 1'b0;
         scan_cnt_ff      <= '0;
         found_valid_ff   <= 1'b0;
         next_id_ff       <= ID_FIRST;
         birth_ff         <= '0;
         death_ff         <= '0;
         split_ff         <= '0;
         comp_ff          <= '0;
         ovf_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         first_iso_ff     <= first_iso_in;
         min_drift_ff     <= min_drift_in;
         drift_factor_ff  <= drift_factor_in;
         sum_ff           <= sum_in;
         pcnt_ff          <= pcnt_in;
         coord_ff         <= coord_in;
         bank_ff          <= bank_in;
         prev_size_ff     <= prev_size_in;
         cur_size_ff      <= cur_size_in;
         claimed_ff       <= claimed_in;
         claim_cnt_ff     <= claim_cnt_in;
         group_index_ff   <= group_index_in;
         group_open_ff    <= group_open_in;
         threshold_sq_ff  <= threshold_sq_in;
         threshold_set_ff <= threshold_set_in;
         scan_cnt_ff      <= scan_cnt_in;
         found_valid_ff   <= found_valid_in;
         next_id_ff       <= next_id_in;
         birth_ff         <= birth_in;
         death_ff         <= death_in;
         split_ff         <= split_in;
         comp_ff          <= comp_in;
         ovf_ff           <= ovf_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      layer_ff        <= layer_in;
      thick_ff        <= thick_in;
      done_ff         <= done_in;
      cent_ff         <= cent_in;
      thr_ff          <= thr_in;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      best_ff         <= best_in;
      found_idx_ff    <= found_idx_in;
      found_branch_ff <= found_branch_in;
      branch_ff       <= branch_in;
      event_ff        <= event_in;
      rsp_ff          <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CTB_ASSERT_NOW(a_claim_bound, clock, reset, claim_cnt_ff <= prev_size_ff, "claims exceed ancestors")
   `CTB_ASSERT_NOW(a_cur_bound, clock, reset, cur_size_ff <= SW'(MAX_COMPONENTS), "table overrun")
   `CTB_ASSERT_NOW(a_div_owner, clock, reset, !div_done || (state_ff == S_DIV_WAIT), "stray divide")
   `CTB_ASSERT_NEXT(a_done_clear, clock, reset, fin_go && done_ff, cleared_ok, "state left behind")

endmodule

// ----- sim/tb_centroid_branch_tracker.sv -----
`default_nettype none

module tb_centroid_branch_tracker;
   import ctb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 16;
   localparam int POINT_LIMIT  = 65536;
   localparam int DRAIN_CYCLES = 300;
   localparam int CYCLE_LIMIT  = 5000000;
   localparam int PHASE_ITEMS  = 240;

   typedef struct {
      req_type     req;
      bit          typed;
      logic [15:0] branch;
      logic [1:0]  ev;
   } step_row;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FIRST_ISO;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   centroid_branch_tracker u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // register shadow
   logic [15:0] cfg_first_iso;
   logic [31:0] cfg_min_drift;
   logic [15:0] cfg_factor;

   // tracker state
   longint          sum_x, sum_y, sum_z;
   int unsigned     pt_count;
   longint          anc_x[TABLE_DEPTH], anc_y[TABLE_DEPTH], anc_z[TABLE_DEPTH];
   logic [15:0]     anc_br[TABLE_DEPTH];
   bit              anc_claim[TABLE_DEPTH];
   int              anc_n;
   longint          grp_x[TABLE_DEPTH], grp_y[TABLE_DEPTH], grp_z[TABLE_DEPTH];
   logic [15:0]     grp_br[TABLE_DEPTH];
   int              grp_n;
   logic [15:0]     grp_idx;
   bit              grp_open;
   longint unsigned thr_sq;
   bit              thr_set;
   logic [15:0]     next_id;
   logic [15:0]     n_birth, n_death, n_split;
   logic [31:0]     n_comp;
   bit              ovf;

   rsp_type expected_layers[$];
   int      errors = 0;
   int      sent = 0;
   int      results = 0;
   int      settings = 0;
   int      cycles = 0;
   int      send_idle = 0;
   int      recv_idle = 0;

   task automatic clear_tracker();
      sum_x = 0; sum_y = 0; sum_z = 0; pt_count = 0;
      anc_n = 0; grp_n = 0; grp_idx = '0; grp_open = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) anc_claim[i] = 0;
      thr_sq = 0; thr_set = 0; next_id = ID_FIRST;
      n_birth = '0; n_death = '0; n_split = '0; n_comp = '0; ovf = 0;
   endtask

   function automatic logic [15:0] bump16(input logic [15:0] c);
      return (c == CNT16_MAX) ? c : c + 16'd1;
   endfunction

   function automatic longint unsigned dist_term(input longint a, input longint b);
      longint d;
      longint unsigned m;
      d = a - b;
      m = (d < 0) ? longint'(-d) : d;
      return m * m;
   endfunction

   function automatic longint unsigned add_clamp(input longint unsigned a,
                                                 input longint unsigned b);
      longint unsigned s;
      s = a + b;
      return (s < a) ? '1 : s;
   endfunction

   task automatic tally_deaths();
      for (int a = 0; a < anc_n; a++)
         if (!anc_claim[a]) n_death = bump16(n_death);
   endtask

   task automatic take_id(output logic [15:0] id);
      id = next_id;
      if (next_id == 16'd0) ovf = 1;
      else next_id = next_id + 16'd1;
   endtask

   // advance the tracker by one accepted request; queue a layer result if it closes one
   task automatic track_point(input req_type r);
      longint          cx, cy, cz;
      longint unsigned best, d, t;
      int              found;
      logic [15:0]     br;
      logic [1:0]      ev;
      bit              done;
      rsp_type         res;
      cx = 0; cy = 0; cz = 0; found = -1; br = '0; ev = EV_PLANAR;
      done = r.last_point && r.last_layer;
      if (r.point_present && pt_count < POINT_LIMIT) begin
         sum_x += longint'(r.point_x);
         sum_y += longint'(r.point_y);
         sum_z += longint'(r.point_z);
         pt_count++;
      end
      if (!r.last_point) return;
      if (r.layer_index >= cfg_first_iso) begin
         if (pt_count != 0) begin
            cx = sum_x / longint'(pt_count);
            cy = sum_y / longint'(pt_count);
            cz = sum_z / longint'(pt_count);
         end
         if (grp_open && r.layer_index != grp_idx) begin
            tally_deaths();
            for (int a = 0; a < grp_n; a++) begin
               anc_x[a] = grp_x[a]; anc_y[a] = grp_y[a]; anc_z[a] = grp_z[a];
               anc_br[a] = grp_br[a]; anc_claim[a] = 0;
            end
            anc_n = grp_n;
            grp_n = 0;
         end
         grp_open = 1;
         grp_idx = r.layer_index;
         if (!thr_set) begin
            t = (64'(cfg_factor) * 64'(r.thickness)) >> 8;
            if (t < 64'(cfg_min_drift)) t = 64'(cfg_min_drift);
            thr_sq = (t > 64'hFFFF_FFFF) ? '1 : t * t;
            thr_set = 1;
         end
         best = thr_sq;
         for (int a = 0; a < anc_n; a++) begin
            d = add_clamp(add_clamp(dist_term(cx, anc_x[a]), dist_term(cy, anc_y[a])),
                          dist_term(cz, anc_z[a]));
            if (d < best) begin
               best = d;
               found = a;
            end
         end
         if (found < 0) begin
            take_id(br);
            ev = EV_BIRTH;
            n_birth = bump16(n_birth);
         end else if (!anc_claim[found]) begin
            anc_claim[found] = 1;
            br = anc_br[found];
            ev = EV_INHERIT;
         end else begin
            take_id(br);
            ev = EV_SPLIT;
            n_split = bump16(n_split);
         end
         if (grp_n < TABLE_DEPTH) begin
            grp_x[grp_n] = cx; grp_y[grp_n] = cy; grp_z[grp_n] = cz;
            grp_br[grp_n] = br;
            grp_n++;
         end else begin
            ovf = 1;
         end
         n_comp++;
      end
      sum_x = 0; sum_y = 0; sum_z = 0; pt_count = 0;
      if (done) tally_deaths();
      res.layer_branch = br;
      res.event_res    = ev;
      res.births       = n_birth;
      res.deaths       = n_death;
      res.splits       = n_split;
      res.components   = n_comp;
      res.branches     = next_id - 16'd1;
      res.done_res     = done;
      res.overflow     = ovf;
      expected_layers.insert(expected_layers.size(), res);
      if (done) clear_tracker();
   endtask

   task automatic field_check(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results++;
         if (expected_layers.size() == 0) begin
            $error("layer result with none pending: layer_branch %0h",
                   rsp_payload.layer_branch);
            errors++;
         end else begin
            want = expected_layers.pop_front();
            field_check("layer_branch", want.layer_branch, rsp_payload.layer_branch);
            field_check("event_res", want.event_res, rsp_payload.event_res);
            field_check("births", want.births, rsp_payload.births);
            field_check("deaths", want.deaths, rsp_payload.deaths);
            field_check("splits", want.splits, rsp_payload.splits);
            field_check("components", want.components, rsp_payload.components);
            field_check("branches", want.branches, rsp_payload.branches);
            field_check("done_res", want.done_res, rsp_payload.done_res);
            field_check("overflow", want.overflow, rsp_payload.overflow);
         end
      end
   end

   always @(negedge clock) rsp_ready = ($urandom_range(99) >= recv_idle);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // called at a falling edge; returns at a falling edge after acceptance
   task automatic send_point(input req_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_payload = r;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      track_point(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_FIRST_ISO:    cfg_first_iso = data[15:0];
         CSR_MIN_DRIFT:    cfg_min_drift = data;
         CSR_DRIFT_FACTOR: cfg_factor = data[15:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (expected_layers.size() != 0) @(negedge clock);
   endtask

   function automatic req_type mk(input logic [15:0] idx, input logic [31:0] x,
                                  input logic [31:0] y, input logic [31:0] z,
                                  input logic [31:0] thick, input bit pres,
                                  input bit lastp, input bit lastl);
      req_type r;
      r.layer_index = idx; r.point_x = x; r.point_y = y; r.point_z = z;
      r.thickness = thick; r.point_present = pres; r.last_point = lastp;
      r.last_layer = lastl;
      return r;
   endfunction

   function automatic logic [31:0] near(input int center);
      return 32'(center + int'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000);
   endfunction

   // one run of layers ending on a final layer; mostly tracks near a few centers
   task automatic run_sequence();
      int          n_layers, n_pts, cx, cy, cz;
      bit          wide, hold_idx;
      logic [15:0] idx;
      logic [31:0] thick;
      req_type     r;
      wide = ($urandom_range(7) == 0);
      hold_idx = ($urandom_range(9) == 0);
      n_layers = hold_idx ? $urandom_range(17, 19) : $urandom_range(1, 12);
      idx = wide ? 16'($urandom()) : 16'($urandom_range(0, 6));
      thick = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(0, 32'h4_0000);
      for (int l = 0; l < n_layers; l++) begin
         if (!hold_idx && $urandom_range(2) == 0) idx = idx + 16'($urandom_range(1, 3));
         n_pts = $urandom_range(1, 4);
         cx = (int'($urandom_range(0, 12)) - 6) * 32'h8000;
         cy = (int'($urandom_range(0, 12)) - 6) * 32'h8000;
         cz = int'(idx) * 32'h1000;
         for (int p = 0; p < n_pts; p++) begin
            if (wide)
               r = mk(idx, $urandom(), $urandom(), $urandom(), thick, 1'b1, 1'b0, 1'b0);
            else
               r = mk(idx, near(cx), near(cy), near(cz), thick, 1'b1, 1'b0, 1'b0);
            r.point_present = ($urandom_range(9) != 0);
            r.last_point = (p == n_pts - 1);
            r.last_layer = r.last_point ? (l == n_layers - 1) : ($urandom_range(7) == 0);
            if (!r.last_point && $urandom_range(15) == 0) r.thickness = $urandom();
            send_point(r);
         end
      end
   endtask

   initial begin
      step_row rows[$];
      logic [31:0] phase_first[4] = '{32'd3, 32'd65535, 32'd2, 32'd0};
      logic [31:0] phase_drift[4] = '{32'd0, 32'hFFFF_FFFF, 32'h3_0000, 32'h1_0000};
      logic [31:0] phase_fact[4]  = '{32'd0, 32'hFFFF, 32'd384, 32'd512};
      int          phase_send[5]  = '{26, 26, 45, 45, 0};
      int          phase_recv[5]  = '{45, 45, 26, 26, 0};
      int          goal;
      rsp_type     tmp;
      cfg_first_iso = '0;
      cfg_min_drift = MIN_DRIFT_RST;
      cfg_factor = DRIFT_FACTOR_RST;
      clear_tracker();

      // default threshold is 2 mm from the first iso layer
      rows.insert(rows.size(), step_row'{mk(0, 0, 0, 0, 32'h1_0000, 1, 1, 0),
                                         1, 16'd1, EV_BIRTH});
      rows.insert(rows.size(), step_row'{mk(1, 32'h8000, 0, 0, 0, 1, 1, 0),
                                         1, 16'd1, EV_INHERIT});
      rows.insert(rows.size(), step_row'{mk(1, 0, 0, 0, 0, 1, 1, 0), 1, 16'd2, EV_SPLIT});
      rows.insert(rows.size(),
                  step_row'{mk(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 1, 0),
                            1, 16'd3, EV_BIRTH});
      rows.insert(rows.size(),
                  step_row'{mk(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1, 0, 0),
                            0, 0, EV_PLANAR});
      rows.insert(rows.size(),
                  step_row'{mk(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0, 0),
                            0, 0, EV_PLANAR});
      rows.insert(rows.size(),
                  step_row'{mk(2, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF, '1, 0, 0, 0),
                            0, 0, EV_PLANAR});
      rows.insert(rows.size(), step_row'{mk(2, 0, 0, 0, 0, 1, 1, 0), 0, 0, EV_PLANAR});
      rows.insert(rows.size(), step_row'{mk(3, 32'hDEAD_BEEF, 0, 0, 0, 0, 1, 0),
                                         0, 0, EV_PLANAR});
      // last_layer without last_point does not end the run
      rows.insert(rows.size(), step_row'{mk(3, 5, 5, 5, 0, 1, 0, 1), 0, 0, EV_PLANAR});
      rows.insert(rows.size(), step_row'{mk(3, 5, 5, 5, 0, 1, 1, 1), 0, 0, EV_PLANAR});
      rows.insert(rows.size(), step_row'{mk(16'hFFFF, 0, 0, 0, '1, 1, 1, 0),
                                         1, 16'd1, EV_BIRTH});
      rows.insert(rows.size(),
                  step_row'{mk(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               '1, 1, 1, 1), 0, 0, EV_PLANAR});

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle = phase_send[0];
      recv_idle = phase_recv[0];
      settings = 1;

      foreach (rows[i]) begin
         send_point(rows[i].req);
         if (rows[i].typed && rows[i].req.last_point) begin
            tmp = expected_layers.pop_back();
            tmp.layer_branch = rows[i].branch;
            tmp.event_res = rows[i].ev;
            expected_layers.insert(expected_layers.size(), tmp);
         end
      end

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            drain();
            repeat (DRAIN_CYCLES) @(negedge clock);
            write_csr(CSR_FIRST_ISO, phase_first[ph-1]);
            write_csr(CSR_MIN_DRIFT, phase_drift[ph-1]);
            write_csr(CSR_DRIFT_FACTOR, phase_fact[ph-1]);
            settings++;
         end
         send_idle = phase_send[ph];
         recv_idle = phase_recv[ph];
         goal = sent + PHASE_ITEMS;
         while (sent < goal) begin
            run_sequence();
            // hold until every pending layer has come back
            if (ph == 0 || $urandom_range(5) == 0) drain();
         end
      end

      req_valid = 1'b0;
      while (expected_layers.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d points over %0d register settings; %0d layer results checked.",
               sent, settings, results);
      if (errors == 0 && expected_layers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/ctb_pkg.sv
rtl/ctb_ram.sv
rtl/ctb_div.sv
rtl/centroid_branch_tracker.sv
sim/tb_centroid_branch_tracker.sv
